// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the ray segment box test RTL.
// No dependencies; included by rsbt_queue, the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m hit");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/rsbt_pkg.sv =====
// Package for the ray segment box test: widths, payload types and helpers.
// No dependencies.
package rsbt_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int WIDE = COORD_WIDTH + 2;
	localparam int T_WIDTH = FRAC_BITS + 1;
	localparam int NUM_AXES = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] start_z;
		logic signed [COORD_WIDTH-1:0] extent_x;
		logic signed [COORD_WIDTH-1:0] extent_y;
		logic signed [COORD_WIDTH-1:0] extent_z;
		logic [COORD_WIDTH-2:0] half_x;
		logic [COORD_WIDTH-2:0] half_y;
		logic [COORD_WIDTH-2:0] half_z;
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [COORD_WIDTH-1:0] center_z;
	} item_t;

	typedef struct packed {
		logic hit;
		axis_t entry_axis;
	} result_t;

	// Classified axis handed from the front part to the back part.
	typedef struct packed {
		logic signed [WIDE-1:0] s;
		logic signed [WIDE-1:0] e;
		logic signed [WIDE-1:0] lo;
		logic signed [WIDE-1:0] hi;
		logic [WIDE-1:0] d;
		logic [WIDE-1:0] m;
		logic div;
		logic sat;
		logic miss;
	} axis_rec_t;

	typedef struct packed {
		axis_rec_t [NUM_AXES-1:0] ax;
	} front_rec_t;
endpackage

// ===== hw/rtl/rsbt_if.sv =====
// Valid/ready channel interface carrying a typed payload.
// Depends on rsbt_pkg for payload types.
interface rsbt_item_if;
	logic valid;
	logic ready;
	rsbt_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rsbt_result_if;
	logic valid;
	logic ready;
	rsbt_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ray_segment_box_test.sv =====
// Top level of the ray segment box test: front part, queue and back part.
// Depends on rsbt_pkg, the channel interfaces and the three submodules.
// Accepts one ray/box pair per cycle while the queue is not full; each result
// passes through the front register, the queue and the bit-per-stage divider that forms t.
// Results come out in order, one per transaction, and the queue lets the front
// keep taking input while the output is stalled, until its four entries are full.
module ray_segment_box_test (
	input logic clk,
	input logic arst_n,
	rsbt_item_if.sink items,
	rsbt_result_if.source results
);
	logic f_valid, f_ready, q_valid, q_ready;
	rsbt_pkg::front_rec_t f_data, q_data;

	rsbt_front u_front (
		.clk, .arst_n,
		.in_valid(items.valid), .in_ready(items.ready), .in_data(items.data),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
	);

	rsbt_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	rsbt_back u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid(results.valid), .out_ready(results.ready), .out_data(results.data)
	);
endmodule

// ===== hw/rtl/rsbt_front.sv =====
// Front part: computes bounds and classifies each axis, one transaction per cycle while out_ready allows.
// Depends on rsbt_pkg.
module rsbt_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rsbt_pkg::item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsbt_pkg::front_rec_t out_data
);
	localparam int W = rsbt_pkg::WIDE;
	localparam int CW = rsbt_pkg::COORD_WIDTH;

	logic signed [CW-1:0] s_a [rsbt_pkg::NUM_AXES];
	logic signed [CW-1:0] e_a [rsbt_pkg::NUM_AXES];
	logic signed [CW-1:0] c_a [rsbt_pkg::NUM_AXES];
	logic [CW-2:0] h_a [rsbt_pkg::NUM_AXES];
	rsbt_pkg::front_rec_t rec;
	rsbt_pkg::front_rec_t rec_s1;
	logic valid_s1;

	assign s_a[0] = in_data.start_x;
	assign s_a[1] = in_data.start_y;
	assign s_a[2] = in_data.start_z;
	assign e_a[0] = in_data.extent_x;
	assign e_a[1] = in_data.extent_y;
	assign e_a[2] = in_data.extent_z;
	assign c_a[0] = in_data.center_x;
	assign c_a[1] = in_data.center_y;
	assign c_a[2] = in_data.center_z;
	assign h_a[0] = in_data.half_x;
	assign h_a[1] = in_data.half_y;
	assign h_a[2] = in_data.half_z;

	always_comb begin
		logic signed [W-1:0] s, e, lo, hi, dl, dh;
		rec = '0;
		for (int i = 0; i < rsbt_pkg::NUM_AXES; i++) begin
			s = W'(s_a[i]);
			e = W'(e_a[i]);
			lo = W'(c_a[i]) - W'(signed'({1'b0, h_a[i]}));
			hi = W'(c_a[i]) + W'(signed'({1'b0, h_a[i]}));
			dl = lo - s;
			dh = s - hi;
			rec.ax[i].s = s;
			rec.ax[i].e = e;
			rec.ax[i].lo = lo;
			rec.ax[i].hi = hi;
			if (s < lo) begin
				rec.ax[i].d = dl;
				rec.ax[i].m = e;
				if (dl > e) begin
					rec.ax[i].miss = 1'b1;
					rec.ax[i].sat = 1'b1;
				end else if (dl >= e) begin
					rec.ax[i].sat = 1'b1;
				end else begin
					rec.ax[i].div = 1'b1;
				end
			end else if (s > hi) begin
				rec.ax[i].d = dh;
				rec.ax[i].m = -e;
				if (dh > -e) begin
					rec.ax[i].miss = 1'b1;
					rec.ax[i].sat = 1'b1;
				end else if (dh >= -e) begin
					rec.ax[i].sat = 1'b1;
				end else begin
					rec.ax[i].div = 1'b1;
				end
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data = rec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rec_s1 <= rec;
		end
	end
endmodule

// ===== hw/rtl/rsbt_queue.sv =====
// Short queue that decouples the front part from the back part.
// Depends on rsbt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rsbt_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rsbt_pkg::front_rec_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsbt_pkg::front_rec_t out_data
);
	localparam int PW = rsbt_pkg::QPTR_W;

	rsbt_pkg::front_rec_t mem_q [rsbt_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (PW+1)'(rsbt_pkg::QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	`ASSERT_NEVER(a_no_over, clk, arst_n, cnt_q > (PW+1)'(rsbt_pkg::QUEUE_DEPTH))
	`ASSERT_CLK(a_cnt_track, clk, arst_n, (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
	`ASSERT_CLK(a_ptr_gap, clk, arst_n, (cnt_q == '0) |-> (wr_q == rd_q))
endmodule

// ===== hw/rtl/rsbt_back.sv =====
// Back part: pipelined restoring divider for t, face choice, scale and bound test.
// Depends on rsbt_pkg.
module rsbt_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rsbt_pkg::front_rec_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsbt_pkg::result_t out_data
);
	localparam int W = rsbt_pkg::WIDE;
	localparam int FB = rsbt_pkg::FRAC_BITS;
	localparam int TW = rsbt_pkg::T_WIDTH;
	localparam int NA = rsbt_pkg::NUM_AXES;
	localparam int PW = W + TW + 1;

	typedef struct packed {
		rsbt_pkg::front_rec_t rec;
		logic [NA-1:0][W:0] rem;
		logic [NA-1:0][TW-1:0] t;
	} stage_t;

	stage_t st_in;
	stage_t st_q [FB];
	logic vld_q [FB];
	logic out_vld_q;
	logic adv;

	// Whole pipeline moves together; the result register is the last stage.
	assign adv = !out_vld_q || out_ready;
	assign in_ready = adv;

	// One quotient bit per stage for every axis that needs a division.
	function automatic stage_t div_step(stage_t cur);
		stage_t nxt;
		logic [W:0] r2;
		nxt = cur;
		for (int i = 0; i < NA; i++) begin
			if (cur.rec.ax[i].div) begin
				r2 = cur.rem[i] << 1;
				nxt.t[i] = cur.t[i] << 1;
				if (r2 >= {1'b0, cur.rec.ax[i].m}) begin
					r2 = r2 - {1'b0, cur.rec.ax[i].m};
					nxt.t[i][0] = 1'b1;
				end
				nxt.rem[i] = r2;
			end
		end
		return nxt;
	endfunction

	// The divider input loads the record.
	always_comb begin
		st_in.rec = in_data;
		for (int i = 0; i < NA; i++) begin
			st_in.rem[i] = {1'b0, in_data.ax[i].d};
			st_in.t[i] = in_data.ax[i].sat ? TW'(1) << FB : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= div_step(st_in);
			for (int k = 1; k < FB; k++) begin
				st_q[k] <= div_step(st_q[k-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FB; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < FB; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Face choice, then scaled products, then bound test.
	rsbt_pkg::axis_t best_c;
	logic [TW-1:0] tb_c;
	always_comb begin
		best_c = rsbt_pkg::AXIS_X;
		tb_c = st_q[FB-1].t[0];
		if (st_q[FB-1].t[1] > tb_c) begin
			best_c = rsbt_pkg::AXIS_Y;
			tb_c = st_q[FB-1].t[1];
		end
		if (st_q[FB-1].t[2] > tb_c) begin
			best_c = rsbt_pkg::AXIS_Z;
			tb_c = st_q[FB-1].t[2];
		end
	end

	rsbt_pkg::axis_t best_s1;
	logic [TW-1:0] tb_s1;
	logic miss_s1;
	rsbt_pkg::front_rec_t rec_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			best_s1 <= best_c;
			tb_s1 <= tb_c;
			rec_s1 <= st_q[FB-1].rec;
			miss_s1 <= st_q[FB-1].rec.ax[0].miss | st_q[FB-1].rec.ax[1].miss
				| st_q[FB-1].rec.ax[2].miss;
		end
	end

	logic signed [PW-1:0] prod_s2 [NA];
	rsbt_pkg::axis_t best_s2;
	logic miss_s2;
	rsbt_pkg::front_rec_t rec_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NA; i++) begin
				prod_s2[i] <= PW'(rec_s1.ax[i].e) * signed'(PW'({1'b0, tb_s1}));
			end
			best_s2 <= best_s1;
			miss_s2 <= miss_s1;
			rec_s2 <= rec_s1;
		end
	end

	logic hit_c;
	always_comb begin
		logic signed [PW-1:0] p;
		hit_c = !miss_s2;
		for (int i = 0; i < NA; i++) begin
			p = PW'(rec_s2.ax[i].s) + (prod_s2[i] >>> FB);
			if (rsbt_pkg::axis_t'(i) != best_s2) begin
				if (p < PW'(rec_s2.ax[i].lo) || p > PW'(rec_s2.ax[i].hi)) hit_c = 1'b0;
			end
		end
	end

	logic v1_q, v2_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			v1_q <= vld_q[FB-1];
			v2_q <= v1_q;
			out_vld_q <= v2_q;
		end
	end

	rsbt_pkg::result_t res_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.hit <= hit_c;
			res_q.entry_axis <= best_s2;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = res_q;
endmodule

// ===== dv/ray_segment_box_test_test.sv =====
// Self-checking testbench for ray_segment_box_test: random and directed ray/box pairs.
// Depends on rsbt_pkg, the channel interfaces in rsbt_if.sv and the block's RTL.
`timescale 1ns / 1ps
module ray_segment_box_test_test;
	localparam int LATENCY = rsbt_pkg::FRAC_BITS + 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint T_ONE = 64'sd1 << rsbt_pkg::FRAC_BITS;

	logic clk;
	logic arst_n;
	rsbt_item_if items ();
	rsbt_result_if results ();

	ray_segment_box_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items.sink),
		.results(results.source)
	);

	rsbt_pkg::item_t pending_rays[$];
	rsbt_pkg::result_t expected_hits[$];
	int cycle_count;
	int errors;
	bit stimulus_done;
	bit calm_phase;
	int hold_cycles;
	bit hold_done;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// floor(d * 2^FRAC_BITS / e) for 0 < d <= e, saturating at 1.0.
	function automatic longint face_fraction(longint d, longint e);
		if (d >= e)
			return T_ONE;
		return (d << rsbt_pkg::FRAC_BITS) / e;
	endfunction

	// floor(e * t / 2^FRAC_BITS), rounding toward minus infinity.
	function automatic longint scale_extent(longint e, longint t);
		longint mag;
		longint q;
		mag = (e < 0) ? -e : e;
		q = (mag * t) >> rsbt_pkg::FRAC_BITS;
		if (e < 0)
			return -q - ((((mag * t) & (T_ONE - 1)) != 0) ? 1 : 0);
		return q;
	endfunction

	function automatic rsbt_pkg::result_t box_hit(rsbt_pkg::item_t it);
		longint s[3], e[3], lo[3], hi[3], t[3], h, c, d, p;
		rsbt_pkg::result_t r;
		int best;
		s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
		e[0] = it.extent_x; e[1] = it.extent_y; e[2] = it.extent_z;
		r.hit = 1'b1;
		best = 0;
		for (int i = 0; i < 3; i++) begin
			h = (i == 0) ? longint'(it.half_x) : (i == 1) ? longint'(it.half_y)
				: longint'(it.half_z);
			c = (i == 0) ? longint'(it.center_x) : (i == 1) ? longint'(it.center_y)
				: longint'(it.center_z);
			lo[i] = c - h;
			hi[i] = c + h;
			if (s[i] < lo[i]) begin
				d = lo[i] - s[i];
				if (d > e[i]) begin
					r.hit = 1'b0;
					t[i] = T_ONE;
				end else begin
					t[i] = face_fraction(d, e[i]);
				end
			end else if (s[i] > hi[i]) begin
				d = hi[i] - s[i];
				if (d < e[i]) begin
					r.hit = 1'b0;
					t[i] = T_ONE;
				end else begin
					t[i] = face_fraction(-d, -e[i]);
				end
			end else begin
				t[i] = 0;
			end
		end
		for (int i = 1; i < 3; i++)
			if (t[i] > t[best])
				best = i;
		for (int i = 0; i < 3; i++) begin
			if (i != best) begin
				p = s[i] + scale_extent(e[i], t[best]);
				if (p < lo[i] || p > hi[i])
					r.hit = 1'b0;
			end
		end
		r.entry_axis = rsbt_pkg::axis_t'(best);
		return r;
	endfunction

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
		endcase
	endfunction

	// Mostly well-formed segments aimed at a box, plus wide-range noise.
	function automatic rsbt_pkg::item_t random_ray();
		rsbt_pkg::item_t it;
		int mode;
		mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
		it.center_x = rand_coord(mode);
		it.center_y = rand_coord(mode);
		it.center_z = rand_coord(mode);
		it.half_x = (mode == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
		it.half_y = (mode == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
		it.half_z = (mode == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
		it.start_x = rand_coord(mode);
		it.start_y = rand_coord(mode);
		it.start_z = rand_coord(mode);
		if (mode != 0 && $urandom_range(0, 2) != 0) begin
			// Aim at a point near the box center.
			it.extent_x = it.center_x - it.start_x + (signed'(rand_coord(1)) >>> 2);
			it.extent_y = it.center_y - it.start_y + (signed'(rand_coord(1)) >>> 2);
			it.extent_z = it.center_z - it.start_z + (signed'(rand_coord(1)) >>> 2);
			if ($urandom_range(0, 1))
				it.extent_x = it.extent_x * 2;
		end else begin
			it.extent_x = rand_coord(mode);
			it.extent_y = rand_coord(mode);
			it.extent_z = rand_coord(mode);
		end
		return it;
	endfunction

	function automatic rsbt_pkg::item_t make_ray(logic [31:0] sx, logic [31:0] sy,
		logic [31:0] sz, logic [31:0] ex, logic [31:0] ey, logic [31:0] ez, logic [30:0] h,
		logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		rsbt_pkg::item_t it;
		it.start_x = sx; it.start_y = sy; it.start_z = sz;
		it.extent_x = ex; it.extent_y = ey; it.extent_z = ez;
		it.half_x = h; it.half_y = h; it.half_z = h;
		it.center_x = cx; it.center_y = cy; it.center_z = cz;
		return it;
	endfunction

	initial begin
		localparam logic [31:0] ONE = 32'h0001_0000;
		localparam logic [31:0] MAXP = 32'h7fff_ffff;
		localparam logic [31:0] MAXN = 32'h8000_0000;
		rsbt_pkg::item_t it;
		stimulus_done = 1'b0;
		// Start inside the box.
		pending_rays.push_back(make_ray(0, 0, 0, ONE, ONE, ONE, ONE, 0, 0, 0));
		// Hits along each axis, both directions.
		pending_rays.push_back(make_ray(-3 * ONE, 0, 0, 4 * ONE, 0, 0, ONE, 0, 0, 0));
		pending_rays.push_back(make_ray(0, 3 * ONE, 0, 0, -4 * ONE, 0, ONE, 0, 0, 0));
		pending_rays.push_back(make_ray(0, 0, -3 * ONE, 0, 0, 4 * ONE, ONE, 0, 0, 0));
		// Face unreachable: too short, pointing away, zero extent.
		pending_rays.push_back(make_ray(-3 * ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, 0));
		pending_rays.push_back(make_ray(-3 * ONE, 0, 0, -ONE, 0, 0, ONE, 0, 0, 0));
		pending_rays.push_back(make_ray(0, 0, 3 * ONE, 0, 0, 0, ONE, 0, 0, 0));
		// Exactly reaching the face, and t ties between axes.
		pending_rays.push_back(make_ray(-2 * ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, 0));
		pending_rays.push_back(make_ray(-2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE,
			2 * ONE, ONE, 0, 0, 0));
		// Miss on the y axis, which points away from the box.
		pending_rays.push_back(make_ray(-3 * ONE, 5 * ONE, 0, 4 * ONE, ONE, 0, ONE, 0, 0, 0));
		// Field extremes.
		pending_rays.push_back(make_ray(MAXN, MAXN, MAXN, MAXP, MAXP, MAXP, 31'h7fff_ffff,
			MAXP, MAXP, MAXP));
		pending_rays.push_back(make_ray(MAXP, MAXP, MAXP, MAXN, MAXN, MAXN, 31'h7fff_ffff,
			MAXN, MAXN, MAXN));
		pending_rays.push_back(make_ray(MAXN, MAXP, 0, MAXP, MAXN, 0, 0, MAXP, MAXN, 0));
		pending_rays.push_back(make_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff));
		pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_rays.push_back(make_ray(-5, 1, 1, 7, -3, 3, 1, 0, 0, 0));
		for (int n = 0; n < 700; n++) begin
			it = random_ray();
			pending_rays.push_back(it);
		end
		stimulus_done = 1'b1;
	end

	// Driver: offers the queued items with random gaps, none in the calm phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
			items.data <= '0;
		end else begin
			if (items.valid && items.ready) begin
				expected_hits.push_back(box_hit(items.data));
				void'(pending_rays.pop_front());
			end
			if (items.valid && !items.ready) begin
				// Hold the offered item until it is taken.
			end else if (pending_rays.size() > 0
				&& (calm_phase || $urandom_range(0, 99) >= 35)) begin
				items.valid <= 1'b1;
				items.data <= pending_rays[0];
			end else begin
				items.valid <= 1'b0;
			end
		end
	end

	// One long hold-off early on so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && cycle_count >= 300) begin
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles >= 200)
				hold_done <= 1'b1;
		end
	end

	// Monitor: checks each result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		rsbt_pkg::result_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected result transaction: hit=%0b entry_axis=%0d",
						results.data.hit, results.data.entry_axis);
					errors++;
				end else begin
					want = expected_hits.pop_front();
					if (results.data.hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, results.data.hit);
						errors++;
					end
					if (results.data.entry_axis !== want.entry_axis) begin
						$error("entry_axis: expected %0d, actual %0d", want.entry_axis,
							results.data.entry_axis);
						errors++;
					end
				end
			end
			if (!hold_done && cycle_count >= 300) begin
				results.ready <= 1'b0;
			end else begin
				results.ready <= calm_phase || $urandom_range(0, 99) >= 35;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		calm_phase <= cycle_count >= 1200 && cycle_count < 2000;
	end

	initial begin
		errors = 0;
		cycle_count = 0;
		calm_phase = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				wait (stimulus_done && pending_rays.size() == 0 && !items.valid
					&& expected_hits.size() == 0);
				repeat (4 * LATENCY) @(posedge clk);
				if (errors == 0)
					$display("SCOREBOARD CLEAN");
				else
					$display("SCOREBOARD MISMATCH");
				$finish;
			end
			begin
				wait (cycle_count >= CYCLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		join
	end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rsbt_pkg.sv
hw/rtl/rsbt_if.sv
hw/rtl/rsbt_front.sv
hw/rtl/rsbt_queue.sv
hw/rtl/rsbt_back.sv
hw/rtl/ray_segment_box_test.sv
dv/ray_segment_box_test_test.sv
